### hdl/gspdd_pkg.sv
`timescale 1ns / 1ps

package gspdd_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int DIV_STEPS = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_THR  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DELAY_THR = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_QLIMIT    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALPHA     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_BASE      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_ADAPT     = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_CUM   = 3'd7;

    localparam logic [1:0] MODE_BASIC = 2'd0;
    localparam logic [1:0] MODE_ADAPT = 2'd1;
    localparam logic [1:0] MODE_DELAY = 2'd2;

    localparam logic CMD_DEQ = 1'b1;

    localparam logic [23:0] QLIMIT_RST  = 24'd1000;
    localparam logic [7:0]  ALPHA_RST   = 8'd32;
    localparam logic [31:0] BASE_RST    = 32'd200000;
    localparam logic [31:0] ADAPT_RST   = 32'd1000000;
    localparam logic [31:0] MAX_CUM_RST = 32'd60000000;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ENQ_BASIC,
        OP_ENQ_ADAPT,
        OP_ENQ_DELAY,
        OP_DEQ_ADAPT,
        OP_DEQ_DELAY
    } op_t;

    typedef enum logic [1:0] {
        PH_NORMAL,
        PH_OVERFLOW,
        PH_DRAIN,
        PH_CLEAR
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_SUB,
        ST_CLAMP,
        ST_DEN,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [23:0] size_threshold;
        logic [31:0] delay_threshold;
        logic [23:0] queue_limit;
        logic [7:0]  alpha;
        logic [31:0] base_interval;
        logic [31:0] adapt_time;
        logic [31:0] max_cum_time;
    } cfg_t;

    typedef struct packed {
        op_t         op;
        logic        want_size;
        logic        over_limit;
        logic        level_zero;
        logic        level_gt;
        logic [31:0] now;
        logic [31:0] soj;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [31:0] time_mask(input int bits);
        logic [63:0] m;
        m = (bits >= 32) ? 64'hFFFF_FFFF : ((64'd1 << bits) - 64'd1);
        return m[31:0];
    endfunction

endpackage

### hdl/gspdd_front.sv
`timescale 1ns / 1ps

module gspdd_front #(
    parameter int TIME_BITS = gspdd_pkg::TIME_BITS_DEF
) (
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                cmd,
    input  logic [31:0]         now_time,
    input  logic [23:0]         queue_level,
    input  logic [15:0]         packet_size,
    input  logic [31:0]         sojourn_time,
    input  gspdd_pkg::cfg_t     cfg,
    input  gspdd_pkg::q_stat_t  qstat,
    output logic                push,
    output gspdd_pkg::item_t    item
);

    localparam logic [31:0] TMASK = gspdd_pkg::time_mask(TIME_BITS);

    logic [24:0]    level_sum;
    gspdd_pkg::op_t op;

    assign level_sum = 25'(queue_level) + 25'(packet_size);

    always_comb
    begin
        case (cfg.mode)
            gspdd_pkg::MODE_BASIC:
            begin
                op = (cmd == gspdd_pkg::CMD_DEQ) ? gspdd_pkg::OP_NONE : gspdd_pkg::OP_ENQ_BASIC;
            end
            gspdd_pkg::MODE_ADAPT:
            begin
                op = (cmd == gspdd_pkg::CMD_DEQ) ? gspdd_pkg::OP_DEQ_ADAPT
                                                 : gspdd_pkg::OP_ENQ_ADAPT;
            end
            gspdd_pkg::MODE_DELAY:
            begin
                op = (cmd == gspdd_pkg::CMD_DEQ) ? gspdd_pkg::OP_DEQ_DELAY
                                                 : gspdd_pkg::OP_ENQ_DELAY;
            end
            default:
            begin
                op = gspdd_pkg::OP_NONE;
            end
        endcase
    end

    always_comb
    begin
        item.op         = op;
        item.want_size  = level_sum > 25'(cfg.size_threshold);
        item.over_limit = level_sum > 25'(cfg.queue_limit);
        item.level_zero = (queue_level == 24'd0);
        item.level_gt   = queue_level > cfg.size_threshold;
        item.now        = now_time & TMASK;
        item.soj        = sojourn_time & TMASK;
    end

    assign in_stall = qstat.full;
    assign push     = in_valid && !qstat.full;

endmodule

### hdl/gspdd_fifo.sv
`timescale 1ns / 1ps

module gspdd_fifo #(
    parameter int DEPTH = gspdd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  gspdd_pkg::item_t    item_in,
    input  logic                pop,
    output gspdd_pkg::item_t    item_out,
    output gspdd_pkg::q_stat_t  stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gspdd_pkg::item_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    assign item_out   = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

### hdl/gspdd_div.sv
`timescale 1ns / 1ps

module gspdd_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [31:0]           rem_init,
    input  logic [31:0]           low_init,
    input  logic [32:0]           divisor,
    output logic [31:0]           quotient,
    output gspdd_pkg::div_stat_t  stat
);

    localparam int CNT_W = $clog2(gspdd_pkg::DIV_STEPS);

    logic [32:0]      rem_reg;
    logic [31:0]      low_reg;
    logic [32:0]      den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [33:0]      trial;
    logic [33:0]      diff;
    logic             fits;

    assign trial = {rem_reg, low_reg[31]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == CNT_W'(gspdd_pkg::DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, rem_init};
            low_reg <= low_init;
            den_reg <= divisor;
            cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[32:0] : trial[32:0];
            low_reg <= {low_reg[30:0], fits};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign quotient  = low_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### hdl/gspdd_back.sv
`timescale 1ns / 1ps

module gspdd_back #(
    parameter int TIME_BITS = gspdd_pkg::TIME_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gspdd_pkg::cfg_t     cfg,
    input  logic                base_load,
    input  logic [31:0]         base_value,
    input  gspdd_pkg::item_t    head,
    input  gspdd_pkg::q_stat_t  qstat,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                drop,
    output logic [31:0]         current_interval
);

    localparam logic [31:0] TMASK = gspdd_pkg::time_mask(TIME_BITS);

    gspdd_pkg::state_t    state_reg;
    gspdd_pkg::state_t    state_next;
    gspdd_pkg::phase_t    phase_reg;
    gspdd_pkg::phase_t    phase_next;
    gspdd_pkg::item_t     work_reg;
    gspdd_pkg::item_t     work_next;
    logic [31:0]          cum_reg;
    logic [31:0]          cum_next;
    logic [31:0]          above_reg;
    logic [31:0]          above_next;
    logic [31:0]          below_reg;
    logic [31:0]          below_next;
    logic [31:0]          interval_reg;
    logic [31:0]          interval_next;
    logic [31:0]          last_soj_reg;
    logic [31:0]          last_soj_next;
    logic [TIME_BITS-1:0] holdoff_reg;
    logic [TIME_BITS-1:0] holdoff_next;
    logic [39:0]          wprod_reg;
    logic [39:0]          wprod_next;
    logic [40:0]          sum_reg;
    logic [40:0]          sum_next;
    logic [40:0]          sub_reg;
    logic [40:0]          sub_next;
    logic [63:0]          prod_reg;
    logic [63:0]          prod_next;
    logic                 den_zero_reg;
    logic                 den_zero_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 drop_reg;
    logic                 drop_next;
    logic [31:0]          out_interval_reg;
    logic [31:0]          out_interval_next;

    logic                 out_free;
    logic                 want;
    logic                 fire;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] hold_sum;
    logic [32:0]          den;
    logic                 div_start;
    logic [31:0]          div_q;
    gspdd_pkg::div_stat_t dstat;

    gspdd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (prod_reg[63:32]),
        .low_init (prod_reg[31:0]),
        .divisor  (den),
        .quotient (div_q),
        .stat     (dstat)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign now_t    = TIME_BITS'(work_reg.now);
    assign hold_sum = now_t + TIME_BITS'(interval_reg);
    assign den      = 33'(cfg.adapt_time) + 33'(cum_reg);
    assign fire     = want && (now_t > holdoff_reg);

    always_comb
    begin
        case (work_reg.op)
            gspdd_pkg::OP_ENQ_BASIC: want = work_reg.want_size;
            gspdd_pkg::OP_ENQ_ADAPT: want = work_reg.want_size;
            gspdd_pkg::OP_ENQ_DELAY: want = last_soj_reg > cfg.delay_threshold;
            default:                 want = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gspdd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        work_next         = work_reg;
        cum_next          = cum_reg;
        above_next        = above_reg;
        below_next        = below_reg;
        interval_next     = interval_reg;
        last_soj_next     = last_soj_reg;
        holdoff_next      = holdoff_reg;
        wprod_next        = wprod_reg;
        sum_next          = sum_reg;
        sub_next          = sub_reg;
        prod_next         = prod_reg;
        den_zero_next     = den_zero_reg;
        out_valid_next    = out_valid_reg;
        drop_next         = drop_reg;
        out_interval_next = out_interval_reg;
        pop               = 1'b0;
        div_start         = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            gspdd_pkg::ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop        = 1'b1;
                    work_next  = head;
                    wprod_next = 40'(above_reg) * 40'(cfg.alpha);
                    if (head.op == gspdd_pkg::OP_ENQ_ADAPT)
                    begin
                        if (head.over_limit)
                        begin
                            phase_next = gspdd_pkg::PH_OVERFLOW;
                        end
                        else if (phase_reg == gspdd_pkg::PH_OVERFLOW && head.level_zero)
                        begin
                            phase_next = gspdd_pkg::PH_DRAIN;
                        end
                        else if (phase_reg == gspdd_pkg::PH_DRAIN && head.level_gt)
                        begin
                            phase_next = gspdd_pkg::PH_CLEAR;
                        end
                        state_next = gspdd_pkg::ST_ACC;
                    end
                    else
                    begin
                        state_next = gspdd_pkg::ST_FIN;
                    end
                end
            end
            gspdd_pkg::ST_ACC:
            begin
                sum_next   = 41'(cum_reg) + 41'(wprod_reg[39:4]);
                prod_next  = 64'(cfg.base_interval) * 64'(cfg.adapt_time);
                state_next = gspdd_pkg::ST_SUB;
            end
            gspdd_pkg::ST_SUB:
            begin
                if (phase_reg == gspdd_pkg::PH_CLEAR)
                begin
                    sub_next = (sum_reg > 41'(below_reg)) ? sum_reg - 41'(below_reg) : '0;
                end
                else
                begin
                    sub_next = sum_reg;
                end
                state_next = gspdd_pkg::ST_CLAMP;
            end
            gspdd_pkg::ST_CLAMP:
            begin
                cum_next   = (sub_reg > 41'(cfg.max_cum_time)) ? cfg.max_cum_time
                                                               : sub_reg[31:0];
                state_next = gspdd_pkg::ST_DEN;
            end
            gspdd_pkg::ST_DEN:
            begin
                den_zero_next = (den == '0);
                div_start     = 1'b1;
                state_next    = gspdd_pkg::ST_DIV;
            end
            gspdd_pkg::ST_DIV:
            begin
                if (dstat.done)
                begin
                    interval_next = den_zero_reg ? cfg.base_interval : div_q;
                    state_next    = gspdd_pkg::ST_FIN;
                end
            end
            gspdd_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    drop_next         = fire;
                    out_interval_next = interval_reg;
                    if (fire)
                    begin
                        holdoff_next = hold_sum;
                    end
                    if (work_reg.op == gspdd_pkg::OP_DEQ_ADAPT)
                    begin
                        if (work_reg.soj > cfg.delay_threshold)
                        begin
                            above_next = (work_reg.soj - cfg.delay_threshold) & TMASK;
                        end
                        else
                        begin
                            below_next = (cfg.delay_threshold - work_reg.soj) & TMASK;
                        end
                    end
                    if (work_reg.op == gspdd_pkg::OP_DEQ_DELAY)
                    begin
                        last_soj_next = work_reg.soj;
                    end
                    state_next = gspdd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gspdd_pkg::ST_IDLE;
            end
        endcase

        if (base_load)
        begin
            interval_next = base_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= gspdd_pkg::PH_NORMAL;
            cum_reg       <= '0;
            above_reg     <= '0;
            below_reg     <= '0;
            interval_reg  <= gspdd_pkg::BASE_RST;
            last_soj_reg  <= '0;
            holdoff_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cum_reg       <= cum_next;
            above_reg     <= above_next;
            below_reg     <= below_next;
            interval_reg  <= interval_next;
            last_soj_reg  <= last_soj_next;
            holdoff_reg   <= holdoff_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg         <= work_next;
        wprod_reg        <= wprod_next;
        sum_reg          <= sum_next;
        sub_reg          <= sub_next;
        prod_reg         <= prod_next;
        den_zero_reg     <= den_zero_next;
        drop_reg         <= drop_next;
        out_interval_reg <= out_interval_next;
    end

    assign out_valid        = out_valid_reg;
    assign drop             = drop_reg;
    assign current_interval = out_interval_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gspdd_pkg::ST_CLAMP) |=> (cum_reg <= cfg.max_cum_time))
    else $error("accumulated time above its saturation limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gspdd_pkg::ST_DIV && dstat.done && !den_zero_reg)
        |-> (div_q <= cfg.base_interval))
    else $error("adapted interval exceeds base interval");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gspdd_pkg::ST_DIV) |-> (dstat.busy || dstat.done))
    else $error("waiting on divider that is not running");
`endif

endmodule

### hdl/gsp_aqm_drop_decider_core.sv
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  cmd, now_time, queue_level, packet_size, sojourn_time
// out      output     out_valid/out_stall  drop, current_interval
// cfg      input      cfg_wr_en            cfg_addr, cfg_data
//
// Basic, delay and dequeue words go from IDLE straight to FIN in the back end; an adaptive
// enqueue passes ACC, SUB, CLAMP, DEN and DIV too; DIV waits on the 32-step bit-serial divider.
// Reset is asynchronous active low; no clearing pass, state is ready at once.
// Input stalls while the queue (QUEUE_DEPTH entries, 2 by default) between the ends is full.
// A result waits in the output register while out_stall is high.
`timescale 1ns / 1ps

module gsp_aqm_drop_decider_core #(
    parameter int TIME_BITS   = gspdd_pkg::TIME_BITS_DEF,
    parameter int QUEUE_DEPTH = gspdd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [gspdd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [31:0]                      cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             cmd,
    input  logic [31:0]                      now_time,
    input  logic [23:0]                      queue_level,
    input  logic [15:0]                      packet_size,
    input  logic [31:0]                      sojourn_time,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             drop,
    output logic [31:0]                      current_interval
);

    gspdd_pkg::cfg_t    cfg_reg;
    gspdd_pkg::cfg_t    cfg_next;
    gspdd_pkg::item_t   front_item;
    gspdd_pkg::item_t   head_item;
    gspdd_pkg::q_stat_t qstat;
    logic               push;
    logic               pop;
    logic               base_load;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_addr)
                gspdd_pkg::CFG_MODE:      cfg_next.mode            = cfg_data[1:0];
                gspdd_pkg::CFG_SIZE_THR:  cfg_next.size_threshold  = cfg_data[23:0];
                gspdd_pkg::CFG_DELAY_THR: cfg_next.delay_threshold = cfg_data;
                gspdd_pkg::CFG_QLIMIT:    cfg_next.queue_limit     = cfg_data[23:0];
                gspdd_pkg::CFG_ALPHA:     cfg_next.alpha           = cfg_data[7:0];
                gspdd_pkg::CFG_BASE:      cfg_next.base_interval   = cfg_data;
                gspdd_pkg::CFG_ADAPT:     cfg_next.adapt_time      = cfg_data;
                gspdd_pkg::CFG_MAX_CUM:   cfg_next.max_cum_time    = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode            <= gspdd_pkg::MODE_BASIC;
            cfg_reg.size_threshold  <= '0;
            cfg_reg.delay_threshold <= '0;
            cfg_reg.queue_limit     <= gspdd_pkg::QLIMIT_RST;
            cfg_reg.alpha           <= gspdd_pkg::ALPHA_RST;
            cfg_reg.base_interval   <= gspdd_pkg::BASE_RST;
            cfg_reg.adapt_time      <= gspdd_pkg::ADAPT_RST;
            cfg_reg.max_cum_time    <= gspdd_pkg::MAX_CUM_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign base_load = cfg_wr_en && (cfg_addr == gspdd_pkg::CFG_BASE);

    gspdd_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .now_time     (now_time),
        .queue_level  (queue_level),
        .packet_size  (packet_size),
        .sojourn_time (sojourn_time),
        .cfg          (cfg_reg),
        .qstat        (qstat),
        .push         (push),
        .item         (front_item)
    );

    gspdd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .pop      (pop),
        .item_out (head_item),
        .stat     (qstat)
    );

    gspdd_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .base_load        (base_load),
        .base_value       (cfg_data),
        .head             (head_item),
        .qstat            (qstat),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .drop             (drop),
        .current_interval (current_interval)
    );

endmodule

### test/gsp_aqm_drop_decider_core_test.sv
`timescale 1ns / 1ps

module gsp_aqm_drop_decider_core_test;

    localparam logic       CMD_ENQ     = 1'b0;
    localparam logic       CMD_DEQ     = gspdd_pkg::CMD_DEQ;
    localparam logic [31:0] RST_IVL    = gspdd_pkg::BASE_RST;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         LIMIT       = 2000000;
    localparam int         PHASES      = 8;
    localparam int         PER_PHASE   = 138;
    localparam int         HOLD_CYCLES = 300;

    typedef struct packed {
        logic        drop;
        logic [31:0] ivl;
    } out_word_t;

    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  reg_idx;
        logic [31:0] reg_val;
        logic        cmd;
        logic [31:0] now;
        logic [23:0] lvl;
        logic [15:0] sz;
        logic [31:0] soj;
        logic        typed;
        logic        exp_drop;
        logic [31:0] exp_ivl;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [31:0] now_time;
    logic [23:0] queue_level;
    logic [15:0] packet_size;
    logic [31:0] sojourn_time;
    logic        out_valid;
    logic        out_stall;
    logic        drop;
    logic [31:0] current_interval;

    // register copies
    logic [1:0]  r_mode;
    logic [23:0] r_size_thr;
    logic [31:0] r_delay_thr;
    logic [23:0] r_qlimit;
    logic [7:0]  r_alpha;
    logic [31:0] r_base;
    logic [31:0] r_adapt;
    logic [31:0] r_max_cum;

    // decider state
    logic [31:0]       hold_end;
    logic [31:0]       cum_t;
    logic [31:0]       above_t;
    logic [31:0]       below_t;
    gspdd_pkg::phase_t phase_now;
    logic [31:0]       cur_ivl;
    logic [31:0]       last_soj;

    out_word_t   expected_words [$];
    out_word_t   head_w;
    dir_row_t    dir_tab [$];
    int          err_cnt = 0;
    int unsigned cycle_cnt = 0;
    bit          calm;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;

    logic        g_cmd;
    logic [31:0] t_now;
    logic [23:0] g_lvl;
    logic [15:0] g_sz;
    logic [31:0] g_soj;
    int          n;

    gsp_aqm_drop_decider_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .now_time(now_time),
        .queue_level(queue_level),
        .packet_size(packet_size),
        .sojourn_time(sojourn_time),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .drop(drop),
        .current_interval(current_interval)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
                flag_mismatch("unexpected word", current_interval, 32'd0);
            else
            begin
                head_w = expected_words.pop_front();
                if (drop !== head_w.drop)
                    flag_mismatch("drop", 32'(drop), 32'(head_w.drop));
                if (current_interval !== head_w.ivl)
                    flag_mismatch("current_interval", current_interval, head_w.ivl);
            end
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            out_stall = !calm && ($urandom_range(0, 99) < 8);
        end
    end

    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            gspdd_pkg::CFG_MODE:      r_mode = val[1:0];
            gspdd_pkg::CFG_SIZE_THR:  r_size_thr = val[23:0];
            gspdd_pkg::CFG_DELAY_THR: r_delay_thr = val;
            gspdd_pkg::CFG_QLIMIT:    r_qlimit = val[23:0];
            gspdd_pkg::CFG_ALPHA:     r_alpha = val[7:0];
            gspdd_pkg::CFG_BASE:
            begin
                r_base = val;
                cur_ivl = val;
            end
            gspdd_pkg::CFG_ADAPT:     r_adapt = val;
            gspdd_pkg::CFG_MAX_CUM:   r_max_cum = val;
            default:                  ;
        endcase
    endfunction

    function automatic void adapt_interval(input logic [23:0] lvl, input logic [15:0] sz);
        logic [24:0] total;
        logic [63:0] weighted;
        logic [63:0] acc;
        logic [63:0] den;
        logic [63:0] quo;
        total = {1'b0, lvl} + {9'b0, sz};
        if (total > {1'b0, r_qlimit})
            phase_now = gspdd_pkg::PH_OVERFLOW;
        else if (phase_now == gspdd_pkg::PH_OVERFLOW && lvl == 24'd0)
            phase_now = gspdd_pkg::PH_DRAIN;
        else if (phase_now == gspdd_pkg::PH_DRAIN && lvl > r_size_thr)
            phase_now = gspdd_pkg::PH_CLEAR;
        weighted = 64'(above_t >> 4) * 64'(r_alpha)
                 + ((64'(above_t[3:0]) * 64'(r_alpha)) >> 4);
        acc = 64'(cum_t) + weighted;
        if (phase_now == gspdd_pkg::PH_CLEAR)
            acc = (acc > 64'(below_t)) ? acc - 64'(below_t) : 64'd0;
        if (acc > 64'(r_max_cum))
            acc = 64'(r_max_cum);
        cum_t = acc[31:0];
        den = 64'(r_adapt) + 64'(cum_t);
        if (den == 64'd0)
            cur_ivl = r_base;
        else
        begin
            quo = (64'(r_base) * 64'(r_adapt)) / den;
            cur_ivl = quo[31:0];
        end
    endfunction

    function automatic out_word_t decide_word(input logic c, input logic [31:0] t,
                                              input logic [23:0] lvl, input logic [15:0] sz,
                                              input logic [31:0] j);
        out_word_t   w;
        logic        want;
        logic [24:0] total;
        w = '0;
        want = 1'b0;
        total = {1'b0, lvl} + {9'b0, sz};
        if (c == CMD_ENQ)
        begin
            case (r_mode)
                gspdd_pkg::MODE_BASIC: want = total > {1'b0, r_size_thr};
                gspdd_pkg::MODE_ADAPT:
                begin
                    adapt_interval(lvl, sz);
                    want = total > {1'b0, r_size_thr};
                end
                gspdd_pkg::MODE_DELAY: want = last_soj > r_delay_thr;
                default:               want = 1'b0;
            endcase
            if (want && t > hold_end)
            begin
                w.drop = 1'b1;
                hold_end = t + cur_ivl;
            end
        end
        else if (r_mode == gspdd_pkg::MODE_DELAY)
            last_soj = j;
        else if (r_mode == gspdd_pkg::MODE_ADAPT)
        begin
            if (j > r_delay_thr)
                above_t = j - r_delay_thr;
            else
                below_t = r_delay_thr - j;
        end
        w.ivl = cur_ivl;
        return w;
    endfunction

    task automatic drain_wait();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        drain_wait();
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_data = val;
        apply_reg(idx, val);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic offer_word(input logic c, input logic [31:0] t, input logic [23:0] lvl,
                              input logic [15:0] sz, input logic [31:0] j,
                              input logic typed, input out_word_t want);
        out_word_t pred;
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 8)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        cmd = c;
        now_time = t;
        queue_level = lvl;
        packet_size = sz;
        sojourn_time = j;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = decide_word(c, t, lvl, sz, j);
        expected_words.push_back(typed ? want : pred);
    endtask

    task automatic set_phase(input int p);
        logic [1:0]  m;
        logic [31:0] v_thr, v_dly, v_ql, v_al, v_base, v_ad, v_mc;
        m = gspdd_pkg::MODE_ADAPT;
        v_thr = $urandom_range(0, 2000);
        v_dly = $urandom_range(0, 100000);
        v_ql = $urandom_range(0, 3000);
        v_al = $urandom_range(0, 255);
        v_base = $urandom_range(0, 300000);
        v_ad = $urandom_range(1, 2000000);
        v_mc = $urandom_range(0, 100000000);
        case (p)
            1:
            begin
                v_thr = 32'hFFFFFF;
                v_dly = 32'hFFFFFFFF;
                v_ql = 32'hFFFFFF;
                v_al = 32'hFF;
                v_base = 32'hFFFFFFFF;
                v_ad = 32'hFFFFFFFF;
                v_mc = 32'hFFFFFFFF;
            end
            2:
            begin
                v_thr = 32'd0;
                v_dly = 32'd0;
                v_ql = 32'd0;
                v_al = 32'd0;
                v_base = 32'd0;
                v_ad = 32'd1;
                v_mc = 32'd0;
            end
            3: m = gspdd_pkg::MODE_BASIC;
            4: m = gspdd_pkg::MODE_DELAY;
            5:
            begin
                m = 2'($urandom_range(0, 3));
                v_thr = $urandom();
                v_dly = $urandom();
                v_ql = $urandom();
                v_al = $urandom();
                v_base = $urandom();
                v_ad = $urandom() | 32'd1;
                v_mc = $urandom();
            end
            7: m = 2'($urandom_range(0, 3));
            default: ;
        endcase
        write_reg(gspdd_pkg::CFG_SIZE_THR, v_thr);
        write_reg(gspdd_pkg::CFG_DELAY_THR, v_dly);
        write_reg(gspdd_pkg::CFG_QLIMIT, v_ql);
        write_reg(gspdd_pkg::CFG_ALPHA, v_al);
        write_reg(gspdd_pkg::CFG_BASE, v_base);
        write_reg(gspdd_pkg::CFG_ADAPT, v_ad);
        write_reg(gspdd_pkg::CFG_MAX_CUM, v_mc);
        write_reg(gspdd_pkg::CFG_MODE, 32'(m));
    endtask

    function automatic dir_row_t t_row(input logic c, input logic [31:0] t,
                                       input logic [23:0] lvl, input logic [15:0] sz,
                                       input logic [31:0] j, input logic d,
                                       input logic [31:0] v);
        dir_row_t r;
        r = '0;
        r.cmd = c;
        r.now = t;
        r.lvl = lvl;
        r.sz = sz;
        r.soj = j;
        r.typed = 1'b1;
        r.exp_drop = d;
        r.exp_ivl = v;
        return r;
    endfunction

    function automatic dir_row_t w_row(input logic c, input logic [31:0] t,
                                       input logic [23:0] lvl, input logic [15:0] sz,
                                       input logic [31:0] j);
        dir_row_t r;
        r = t_row(c, t, lvl, sz, j, 1'b0, 32'd0);
        r.typed = 1'b0;
        return r;
    endfunction

    function automatic dir_row_t c_row(input logic [2:0] idx, input logic [31:0] val);
        dir_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = gspdd_pkg::CFG_MODE;
        cfg_data = 32'd0;
        in_valid = 1'b0;
        cmd = CMD_ENQ;
        now_time = 32'd0;
        queue_level = 24'd0;
        packet_size = 16'd0;
        sojourn_time = 32'd0;
        calm = 1'b0;
        r_mode = gspdd_pkg::MODE_BASIC;
        r_size_thr = 24'd0;
        r_delay_thr = 32'd0;
        r_qlimit = gspdd_pkg::QLIMIT_RST;
        r_alpha = gspdd_pkg::ALPHA_RST;
        r_base = gspdd_pkg::BASE_RST;
        r_adapt = gspdd_pkg::ADAPT_RST;
        r_max_cum = gspdd_pkg::MAX_CUM_RST;
        hold_end = 32'd0;
        cum_t = 32'd0;
        above_t = 32'd0;
        below_t = 32'd0;
        phase_now = gspdd_pkg::PH_NORMAL;
        cur_ivl = gspdd_pkg::BASE_RST;
        last_soj = 32'd0;

        dir_tab = '{
            t_row(CMD_ENQ, 32'd0, 24'd0, 16'd0, 32'd0, 1'b0, RST_IVL),
            t_row(CMD_ENQ, 32'd1, 24'd1, 16'd0, 32'd0, 1'b1, RST_IVL),
            t_row(CMD_ENQ, 32'd100, 24'hFFFFFF, 16'hFFFF, 32'd0, 1'b0, RST_IVL),
            t_row(CMD_DEQ, 32'd200, 24'd0, 16'd0, 32'hFFFFFFFF, 1'b0, RST_IVL),
            t_row(CMD_ENQ, 32'hFFFFFFFF, 24'hFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 1'b1, RST_IVL),
            t_row(CMD_ENQ, 32'd199999, 24'd1, 16'd0, 32'd0, 1'b0, RST_IVL),
            t_row(CMD_ENQ, 32'd200000, 24'd1, 16'd0, 32'd0, 1'b1, RST_IVL),
            c_row(gspdd_pkg::CFG_SIZE_THR, 32'd100),
            c_row(gspdd_pkg::CFG_DELAY_THR, 32'd1000),
            c_row(gspdd_pkg::CFG_QLIMIT, 32'd500),
            c_row(gspdd_pkg::CFG_ALPHA, 32'd255),
            c_row(gspdd_pkg::CFG_BASE, 32'd1000000),
            c_row(gspdd_pkg::CFG_MODE, 32'(gspdd_pkg::MODE_ADAPT)),
            w_row(CMD_DEQ, 32'd500000, 24'd0, 16'd0, 32'd5000),
            w_row(CMD_ENQ, 32'd500001, 24'd600, 16'd0, 32'd0),
            w_row(CMD_ENQ, 32'd500002, 24'd0, 16'd0, 32'd0),
            w_row(CMD_DEQ, 32'd500003, 24'd0, 16'd0, 32'd10),
            w_row(CMD_ENQ, 32'd600000, 24'd200, 16'd0, 32'd0),
            w_row(CMD_DEQ, 32'd600001, 24'd0, 16'd0, 32'd1000),
            w_row(CMD_ENQ, 32'd3000000, 24'd50, 16'd60, 32'd0),
            c_row(gspdd_pkg::CFG_MAX_CUM, 32'd5000),
            c_row(gspdd_pkg::CFG_ALPHA, 32'd0),
            w_row(CMD_ENQ, 32'd3000001, 24'd10, 16'd0, 32'd0),
            c_row(gspdd_pkg::CFG_MAX_CUM, 32'd0),
            c_row(gspdd_pkg::CFG_ADAPT, 32'd0),
            c_row(gspdd_pkg::CFG_BASE, 32'hFFFFFFFF),
            t_row(CMD_ENQ, 32'd3000002, 24'd0, 16'd0, 32'd0, 1'b0, 32'hFFFFFFFF),
            c_row(gspdd_pkg::CFG_ADAPT, 32'hFFFFFFFF),
            c_row(gspdd_pkg::CFG_MAX_CUM, 32'hFFFFFFFF),
            c_row(gspdd_pkg::CFG_ALPHA, 32'd16),
            c_row(gspdd_pkg::CFG_MODE, 32'(gspdd_pkg::MODE_DELAY)),
            w_row(CMD_ENQ, 32'd4000000, 24'd0, 16'd0, 32'd0),
            w_row(CMD_DEQ, 32'd4000001, 24'd0, 16'd0, 32'd2000),
            w_row(CMD_ENQ, 32'd4000002, 24'd0, 16'd0, 32'd0),
            w_row(CMD_DEQ, 32'd4000003, 24'd0, 16'd0, 32'd1000),
            w_row(CMD_ENQ, 32'd4000004, 24'd0, 16'd0, 32'd0),
            c_row(gspdd_pkg::CFG_MODE, 32'(MODE_UNUSED)),
            w_row(CMD_ENQ, 32'hFFFFFFFE, 24'hFFFFFF, 16'hFFFF, 32'd0),
            w_row(CMD_DEQ, 32'hFFFFFFFE, 24'd0, 16'd0, 32'hFFFFFFFF),
            c_row(gspdd_pkg::CFG_MODE, 32'(gspdd_pkg::MODE_ADAPT)),
            w_row(CMD_DEQ, 32'd0, 24'd0, 16'd0, 32'hFFFFFFFF),
            w_row(CMD_ENQ, 32'd1, 24'hFFFFFF, 16'hFFFF, 32'd0)
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
                write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            else
                offer_word(dir_tab[i].cmd, dir_tab[i].now, dir_tab[i].lvl, dir_tab[i].sz,
                           dir_tab[i].soj, dir_tab[i].typed,
                           '{drop: dir_tab[i].exp_drop, ivl: dir_tab[i].exp_ivl});
        end

        t_now = $urandom();
        for (int p = 0; p < PHASES; p++)
        begin
            set_phase(p);
            for (int k = 0; k < PER_PHASE; k++)
            begin
                n = p * PER_PHASE + k;
                calm = (n >= 400 && n < 600);
                if (n == 250)
                    hold_req = 1'b1;
                if (n == 800)
                    drain_wait();
                case ($urandom_range(0, 19))
                    0:       t_now = $urandom();
                    1:       ;
                    default: t_now = t_now + $urandom_range(0, (r_base >> 3) + 2000);
                endcase
                g_cmd = $urandom_range(0, 1);
                case ($urandom_range(0, 5))
                    0:       g_lvl = 24'd0;
                    1:       g_lvl = 24'($urandom_range(0, r_size_thr));
                    2:       g_lvl = 24'($urandom_range(0, r_qlimit + 100));
                    3:       g_lvl = 24'($urandom());
                    default: g_lvl = 24'($urandom_range(0, 2 * r_size_thr + 10));
                endcase
                g_sz = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 1500))
                                                    : 16'($urandom());
                if ($urandom_range(0, 4) == 0)
                    g_soj = $urandom();
                else
                    g_soj = r_delay_thr + $urandom_range(0, 40000) - 32'd20000;
                offer_word(g_cmd, t_now, g_lvl, g_sz, g_soj, 1'b0, '0);
            end
        end

        calm = 1'b0;
        drain_wait();
        repeat (50) @(negedge clk);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
hdl/gspdd_pkg.sv
hdl/gspdd_front.sv
hdl/gspdd_fifo.sv
hdl/gspdd_div.sv
hdl/gspdd_back.sv
hdl/gsp_aqm_drop_decider_core.sv
test/gsp_aqm_drop_decider_core_test.sv
